/* rtl/assert_macros.svh */
// Assertion macros shared by the compositor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/scr_pkg.sv */
// Package with the shared types and constants of the scanline ring compositor.
`default_nettype none

package scr_pkg;

  localparam int DEF_RING_SLOTS = 4;
  localparam int DEF_OUT_WIDTH  = 640;
  localparam int DEF_OUT_HEIGHT = 480;

  localparam int LINES_SHORT    = 192;
  localparam int LINES_TALL     = 212;
  localparam int LINE_PIXELS    = 512;
  localparam int ACTIVE_WORDS   = 256;
  localparam int PLAN_LOOKAHEAD = 3;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_PLAN  = 2'd2
  } scr_func_t;

  typedef enum logic [0:0] {
    REG_BORDER_COLOR = 1'd0,
    REG_TALL_MODE    = 1'd1
  } scr_reg_t;

  typedef struct packed {
    logic       en;
    logic [7:0] line;
    logic       first;
    logic       commit;
    logic       wide;
  } scr_tag_wr_t;

endpackage

`default_nettype wire

/* rtl/scr_if.sv */
// Handshake interfaces for the input items and the result items.
`default_nettype none

interface scr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  src_line;
  logic [8:0]  pixel_index;
  logic [15:0] pixel_value;
  logic        wide_line;
  logic        last_pixel;
  logic [8:0]  scan_line;
  logic [8:0]  word_index;

  modport source (
    output valid, func, src_line, pixel_index, pixel_value, wide_line, last_pixel,
           scan_line, word_index,
    input  ready
  );
  modport sink (
    input  valid, func, src_line, pixel_index, pixel_value, wide_line, last_pixel,
           scan_line, word_index,
    output ready
  );
endinterface

interface scr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        miss;
  logic        is_request;
  logic [7:0]  request_line;
  logic        last;

  modport source (
    output valid, out_word, miss, is_request, request_line, last,
    input  ready
  );
  modport sink (
    input  valid, out_word, miss, is_request, request_line, last,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/scanline_ring_compositor.sv */
// Top level of the scanline ring compositor.
`default_nettype none
`include "assert_macros.svh"

// Pixel writes and word reads can transfer one item per cycle while results are taken;
// a read word is registered in the line store read register and then in the output
// register before it appears on the result channel. A plan item holds the request
// stage until it has issued its requests (one to three), one per result item; a plan
// that finds all three lines present gives no result and leaves the stage free. The
// line store needs no clearing pass after reset; only the slot valid bits are cleared.
module scanline_ring_compositor #(
  parameter int RING_SLOTS = scr_pkg::DEF_RING_SLOTS,
  parameter int OUT_WIDTH  = scr_pkg::DEF_OUT_WIDTH,
  parameter int OUT_HEIGHT = scr_pkg::DEF_OUT_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  scr_in_if.sink           items,
  scr_out_if.source        results
);

  localparam int SW         = $clog2(RING_SLOTS);
  localparam int AW         = $clog2(RING_SLOTS * scr_pkg::ACTIVE_WORDS);
  localparam int RW         = 11;
  localparam int CW         = 10;
  localparam int NP         = scr_pkg::PLAN_LOOKAHEAD;
  localparam int YO_SHORT   = (OUT_HEIGHT - 2 * scr_pkg::LINES_SHORT) / 2;
  localparam int YO_TALL    = (OUT_HEIGHT - 2 * scr_pkg::LINES_TALL) / 2;
  localparam int LEFT_WORDS = (OUT_WIDTH - scr_pkg::LINE_PIXELS) / 4;
  localparam int ROW_WORDS  = OUT_WIDTH / 2;

  logic [15:0] border_color;
  logic        tall_mode;

  logic             item_accept;
  scr_pkg::scr_func_t func;
  logic             read_start;
  logic             plan_start;
  logic             write_start;

  logic [RW-1:0] yo;
  logic [RW-1:0] rows_end;
  logic [RW-1:0] scan_x;
  logic [RW-1:0] diff;
  logic [8:0]    n_lines;
  logic          in_span;
  logic          in_rows;
  logic [CW-1:0] wx;
  logic [CW-1:0] col_full;
  logic          in_cols;
  logic [7:0]    beam;
  logic [7:0]    col;
  logic [7:0]    start;
  logic [7:0]    plan_line [NP];
  logic [NP-1:0] plan_hit;

  scr_pkg::scr_tag_wr_t tag_wr;
  logic [SW-1:0] wr_slot;
  logic [SW-1:0] rd_slot;
  logic          rd_hit;
  logic          rd_wide;
  logic          active;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_lo;
  logic [15:0]   rd_hi;

  logic          s1_valid;
  logic          s1_plan;
  logic          s1_border;
  logic          s1_miss;
  logic          s1_wide;
  logic          s1_half;
  logic [NP-1:0] s1_pending;
  logic [7:0]    s1_lines [NP];
  logic          s1_final;
  logic          out_load;
  logic [NP-1:0] sel_mask;
  logic [7:0]    sel_line;

  logic        res_valid;
  logic [31:0] res_word;
  logic        res_miss;
  logic        res_req;
  logic [7:0]  res_line;
  logic        res_last;
  logic [31:0] word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      border_color <= '0;
      tall_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (scr_pkg::scr_reg_t'(cfg_index))
        scr_pkg::REG_BORDER_COLOR: border_color <= cfg_data;
        scr_pkg::REG_TALL_MODE:    tall_mode    <= cfg_data[0];
      endcase
    end
  end

  assign item_accept = items.valid && items.ready;
  assign func        = scr_pkg::scr_func_t'(items.func);
  assign write_start = item_accept && (func == scr_pkg::FUNC_WRITE);
  assign read_start  = item_accept && (func == scr_pkg::FUNC_READ);
  assign plan_start  = item_accept && (func == scr_pkg::FUNC_PLAN) && (plan_hit != '1);

  assign n_lines  = tall_mode ? 9'(scr_pkg::LINES_TALL) : 9'(scr_pkg::LINES_SHORT);
  assign yo       = tall_mode ? RW'(YO_TALL) : RW'(YO_SHORT);
  assign rows_end = yo + {1'b0, n_lines, 1'b0};
  assign scan_x   = RW'(items.scan_line);
  assign in_span  = (scan_x >= yo) && (scan_x < rows_end);
  assign in_rows  = in_span && (scan_x < RW'(OUT_HEIGHT));
  assign diff     = scan_x - yo;
  assign beam     = diff[8:1];

  assign wx       = CW'(items.word_index);
  assign in_cols  = (wx >= CW'(LEFT_WORDS)) && (wx < CW'(LEFT_WORDS + scr_pkg::ACTIVE_WORDS))
                    && (wx < CW'(ROW_WORDS));
  assign col_full = wx - CW'(LEFT_WORDS);
  assign col      = col_full[7:0];
  assign active   = in_rows && in_cols;

  assign start = in_span ? beam + 8'd1 : 8'd0;

  always_comb begin
    logic [8:0] cand;
    for (int k = 0; k < NP; k++) begin
      cand = {1'b0, start} + 9'(k);
      if (cand >= n_lines) begin
        cand = cand - n_lines;
      end
      plan_line[k] = cand[7:0];
    end
  end

  assign tag_wr.en     = write_start;
  assign tag_wr.line   = items.src_line;
  assign tag_wr.first  = (items.pixel_index == 9'd0);
  assign tag_wr.commit = items.last_pixel;
  assign tag_wr.wide   = items.wide_line;

  scr_slot_tags #(
    .RING_SLOTS (RING_SLOTS)
  ) u_tags (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we && (scr_pkg::scr_reg_t'(cfg_index) == scr_pkg::REG_TALL_MODE)),
    .wr        (tag_wr),
    .wr_slot   (wr_slot),
    .rd_line   (beam),
    .rd_hit    (rd_hit),
    .rd_wide   (rd_wide),
    .rd_slot   (rd_slot),
    .plan_line (plan_line),
    .plan_hit  (plan_hit)
  );

  assign rd_addr = {rd_slot, (rd_wide ? col : {1'b0, col[7:1]})};

  scr_line_mem #(
    .RING_SLOTS (RING_SLOTS)
  ) u_mem (
    .clk     (clk),
    .we      (write_start),
    .wr_addr ({wr_slot, items.pixel_index[8:1]}),
    .wr_half (items.pixel_index[0]),
    .wr_data (items.pixel_value),
    .re      (read_start),
    .rd_addr (rd_addr),
    .rd_lo   (rd_lo),
    .rd_hi   (rd_hi)
  );

  always_comb begin
    sel_mask = '0;
    sel_line = s1_lines[0];
    priority if (s1_pending[0]) begin
      sel_mask = NP'(1);
      sel_line = s1_lines[0];
    end else if (s1_pending[1]) begin
      sel_mask = NP'(2);
      sel_line = s1_lines[1];
    end else begin
      sel_mask = NP'(4);
      sel_line = s1_lines[2];
    end
  end

  assign s1_final    = !s1_plan || ($countones(s1_pending) == 1);
  assign out_load    = s1_valid && (!res_valid || results.ready);
  assign items.ready = !s1_valid || (out_load && s1_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (read_start || plan_start) begin
      s1_valid <= 1'b1;
    end else if (out_load && s1_final) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_start || plan_start) begin
      s1_plan    <= plan_start;
      s1_border  <= !(active && rd_hit);
      s1_miss    <= active && !rd_hit;
      s1_wide    <= rd_wide;
      s1_half    <= col[0];
      s1_pending <= ~plan_hit;
      for (int k = 0; k < NP; k++) begin
        s1_lines[k] <= plan_line[k];
      end
    end else if (out_load && s1_plan) begin
      s1_pending <= s1_pending & ~sel_mask;
    end
  end

  always_comb begin
    priority if (s1_border) begin
      word_next = {border_color, border_color};
    end else if (s1_wide) begin
      word_next = {rd_hi, rd_lo};
    end else if (s1_half) begin
      word_next = {rd_hi, rd_hi};
    end else begin
      word_next = {rd_lo, rd_lo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (s1_plan) begin
        res_word <= '0;
        res_miss <= 1'b0;
        res_req  <= 1'b1;
        res_line <= sel_line;
        res_last <= ($countones(s1_pending) == 1);
      end else begin
        res_word <= word_next;
        res_miss <= s1_miss;
        res_req  <= 1'b0;
        res_line <= '0;
        res_last <= 1'b1;
      end
    end
  end

  assign results.valid        = res_valid;
  assign results.out_word     = res_word;
  assign results.miss         = res_miss;
  assign results.is_request   = res_req;
  assign results.request_line = res_line;
  assign results.last         = res_last;

  `ASSERT_IMPLY(a_accept_free, item_accept, !s1_valid || (out_load && s1_final), "Transfer while the request stage was busy.")
  `ASSERT_IMPLY(a_plan_pending, s1_valid && s1_plan, s1_pending != '0, "Plan stage held with no request left.")
  `ASSERT_IMPLY(a_miss_border, s1_valid && !s1_plan && s1_miss, s1_border, "Missed line without border substitution.")

endmodule

`default_nettype wire

/* rtl/scr_slot_tags.sv */
// Slot tag store with valid bits, width flags and associative line lookup.
`default_nettype none
`include "assert_macros.svh"

module scr_slot_tags #(
  parameter int RING_SLOTS = scr_pkg::DEF_RING_SLOTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire scr_pkg::scr_tag_wr_t          wr,
  output logic [$clog2(RING_SLOTS)-1:0]      wr_slot,
  input  wire logic [7:0]                    rd_line,
  output logic                               rd_hit,
  output logic                               rd_wide,
  output logic [$clog2(RING_SLOTS)-1:0]      rd_slot,
  input  wire logic [7:0]                    plan_line [scr_pkg::PLAN_LOOKAHEAD],
  output logic [scr_pkg::PLAN_LOOKAHEAD-1:0] plan_hit
);

  localparam int SW = $clog2(RING_SLOTS);

  logic [RING_SLOTS-1:0] valid;
  logic [7:0]            tag [RING_SLOTS];
  logic                  wide [RING_SLOTS];
  logic [SW-1:0]         slot_lut [256];
  logic [RING_SLOTS-1:0] rd_match;

  for (genvar g = 0; g < 256; g++) begin : g_lut
    assign slot_lut[g] = SW'(g % RING_SLOTS);
  end

  assign wr_slot = slot_lut[wr.line];
  assign rd_slot = slot_lut[rd_line];
  assign rd_wide = wide[rd_slot];
  assign rd_hit  = |rd_match;

  always_comb begin
    for (int s = 0; s < RING_SLOTS; s++) begin
      rd_match[s] = valid[s] && (tag[s] == rd_line);
    end
  end

  always_comb begin
    plan_hit = '0;
    for (int k = 0; k < scr_pkg::PLAN_LOOKAHEAD; k++) begin
      for (int s = 0; s < RING_SLOTS; s++) begin
        if (valid[s] && (tag[s] == plan_line[k])) begin
          plan_hit[k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear) begin
      valid <= '0;
    end else if (wr.en) begin
      if (wr.commit) begin
        valid[wr_slot] <= 1'b1;
      end else if (wr.first) begin
        valid[wr_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.commit) begin
      tag[wr_slot]  <= wr.line;
      wide[wr_slot] <= wr.wide;
    end
  end

  `ASSERT_NEXT(a_clear_empties, clear, valid == '0, "Tag clear left a slot valid.")
  `ASSERT_ALWAYS(a_match_unique, $onehot0(rd_match), "Line matched in more than one slot.")

endmodule

`default_nettype wire

/* rtl/scr_line_mem.sv */
// Line store memory: two pixel halves per word, one write and one read port.
`default_nettype none

module scr_line_mem #(
  parameter int RING_SLOTS = scr_pkg::DEF_RING_SLOTS
) (
  input  wire logic                                                   clk,
  input  wire logic                                                   we,
  input  wire logic [$clog2(RING_SLOTS * scr_pkg::ACTIVE_WORDS)-1:0]  wr_addr,
  input  wire logic                                                   wr_half,
  input  wire logic [15:0]                                            wr_data,
  input  wire logic                                                   re,
  input  wire logic [$clog2(RING_SLOTS * scr_pkg::ACTIVE_WORDS)-1:0]  rd_addr,
  output logic [15:0]                                                 rd_lo,
  output logic [15:0]                                                 rd_hi
);

  localparam int DEPTH = RING_SLOTS * scr_pkg::ACTIVE_WORDS;

  logic [15:0] mem_lo [DEPTH];
  logic [15:0] mem_hi [DEPTH];

  always_ff @(posedge clk) begin
    if (we && !wr_half) begin
      mem_lo[wr_addr] <= wr_data;
    end
    if (we && wr_half) begin
      mem_hi[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_lo <= mem_lo[rd_addr];
      rd_hi <= mem_hi[rd_addr];
    end
  end

endmodule

`default_nettype wire
